FILE: src/ocms_pkg.sv
// shared types, register indexes and constants for the obstacle check mode sequencer
package ocms_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned LIM_W      = 16;
    localparam int unsigned ANGLE_W    = 16;
    localparam int unsigned ALIM_W     = 15;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TMO   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DUR   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_BLINK  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_AVOID_TMO  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIM  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LIM  = 4'd7;

    // reset values of the configuration registers
    localparam logic [LIM_W-1:0]  RST_SUPPRESS  = 16'd1500;
    localparam logic [LIM_W-1:0]  RST_WAIT_TMO  = 16'd5000;
    localparam logic [LIM_W-1:0]  RST_STOP_DUR  = 16'd3000;
    localparam logic [LIM_W-1:0]  RST_STARTUP   = 16'd2000;
    localparam logic [LIM_W-1:0]  RST_LED_BLINK = 16'd3000;
    localparam logic [LIM_W-1:0]  RST_AVOID_TMO = 16'd15000;
    localparam logic [LIM_W-1:0]  RST_RANGE_LIM = 16'd60;
    localparam logic [ALIM_W-1:0] RST_ANGLE_LIM = 15'd6000;

    // e / 200 for e < 2^16 as ((e >> 3) * 5243) >> 17, exact over that range
    localparam logic [12:0] BLINK_RECIP = 13'd5243;
    localparam int unsigned BLINK_SHIFT = 17;

    // encoded mode on the result
    localparam logic [1:0] MODE_FOLLOW = 2'd0;
    localparam logic [1:0] MODE_WAIT   = 2'd1;
    localparam logic [1:0] MODE_STOP   = 2'd2;
    localparam logic [1:0] MODE_AVOID  = 2'd3;

    typedef enum logic [3:0] {
        ST_FOLLOW = 4'b0001,
        ST_WAIT   = 4'b0010,
        ST_STOP   = 4'b0100,
        ST_AVOID  = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [TIME_W-1:0]         now_ms;
        logic [7:0]                line_sensors;
        logic                      junction_pin;
        logic [TIME_W-1:0]         last_turn_ms;
        logic                      steer_side;
        logic                      target_seen;
        logic [15:0]               target_range;
        logic signed [ANGLE_W-1:0] target_angle;
    } t_in;

    typedef struct packed {
        logic [1:0] mode_state;
        logic       walk_enable;
        logic       halt_motors;
        logic       side_write;
        logic       side_value;
        logic       led_on;
        logic       radar_view;
    } t_out;

    typedef struct packed {
        logic [LIM_W-1:0]  suppress_window_ms;
        logic [LIM_W-1:0]  radar_wait_timeout_ms;
        logic [LIM_W-1:0]  stop_hold_ms;
        logic [LIM_W-1:0]  boot_hold_ms;
        logic [LIM_W-1:0]  blink_span_ms;
        logic [LIM_W-1:0]  avoid_span_ms;
        logic [LIM_W-1:0]  range_limit;
        logic [ALIM_W-1:0] angle_limit;
    } t_cfg;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        case (m)
            ST_FOLLOW: c = MODE_FOLLOW;
            ST_WAIT:   c = MODE_WAIT;
            ST_STOP:   c = MODE_STOP;
            ST_AVOID:  c = MODE_AVOID;
            default:   c = MODE_FOLLOW;
        endcase
        return c;
    endfunction

endpackage

FILE: src/ocms_cfg.sv
// configuration register file of the mode sequencer
module ocms_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [ocms_pkg::CFG_IDX_W-1:0]   i_idx,
    input  logic [ocms_pkg::CFG_DATA_W-1:0]  i_data,
    output ocms_pkg::t_cfg                   o_cfg
);

    ocms_pkg::t_cfg r_cfg;
    ocms_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (i_idx)
                ocms_pkg::CFG_SUPPRESS:  n_cfg.suppress_window_ms    = i_data;
                ocms_pkg::CFG_WAIT_TMO:  n_cfg.radar_wait_timeout_ms = i_data;
                ocms_pkg::CFG_STOP_DUR:  n_cfg.stop_hold_ms          = i_data;
                ocms_pkg::CFG_STARTUP:   n_cfg.boot_hold_ms          = i_data;
                ocms_pkg::CFG_LED_BLINK: n_cfg.blink_span_ms         = i_data;
                ocms_pkg::CFG_AVOID_TMO: n_cfg.avoid_span_ms         = i_data;
                ocms_pkg::CFG_RANGE_LIM: n_cfg.range_limit           = i_data;
                ocms_pkg::CFG_ANGLE_LIM:
                    n_cfg.angle_limit = i_data[ocms_pkg::ALIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.suppress_window_ms    <= ocms_pkg::RST_SUPPRESS;
            r_cfg.radar_wait_timeout_ms <= ocms_pkg::RST_WAIT_TMO;
            r_cfg.stop_hold_ms          <= ocms_pkg::RST_STOP_DUR;
            r_cfg.boot_hold_ms          <= ocms_pkg::RST_STARTUP;
            r_cfg.blink_span_ms         <= ocms_pkg::RST_LED_BLINK;
            r_cfg.avoid_span_ms         <= ocms_pkg::RST_AVOID_TMO;
            r_cfg.range_limit           <= ocms_pkg::RST_RANGE_LIM;
            r_cfg.angle_limit           <= ocms_pkg::RST_ANGLE_LIM;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/ocms_ctrl.sv
// mode state machine: state registers and the per-pass next state and result logic
module ocms_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  ocms_pkg::t_in   i_item,
    input  ocms_pkg::t_cfg  i_cfg,
    output ocms_pkg::t_out  o_res
);

    ocms_pkg::t_mode                  r_mode, n_mode;
    logic                             r_pin_prev, n_pin_prev;
    logic [ocms_pkg::TIME_W-1:0]      r_wait_entry, n_wait_entry;
    logic [ocms_pkg::TIME_W-1:0]      r_stop_entry, n_stop_entry;
    logic [ocms_pkg::TIME_W-1:0]      r_avoid_entry, n_avoid_entry;
    logic                             r_tgt_latched, n_tgt_latched;
    logic [ocms_pkg::ANGLE_W-1:0]     r_lat_angle, n_lat_angle;
    logic                             r_saved_side, n_saved_side;

    logic [ocms_pkg::TIME_W-1:0]      wait_el, stop_el, avoid_el, turn_el;
    logic [25:0]                      blink_prod;
    logic                             sensors_dark, rise, suppressed, startup_ok;
    logic                             tgt_hit, tgt_now;
    logic [ocms_pkg::ANGLE_W-1:0]     angle_now;
    logic signed [ocms_pkg::ANGLE_W:0] ang_x, lim_x;
    logic                             led;
    logic                             halt, swrite, svalue;

    always_comb begin
        wait_el  = i_item.now_ms - r_wait_entry;
        stop_el  = i_item.now_ms - r_stop_entry;
        avoid_el = i_item.now_ms - r_avoid_entry;
        turn_el  = i_item.now_ms - i_item.last_turn_ms;

        sensors_dark = (i_item.line_sensors == 8'd0);
        rise         = i_item.junction_pin && !r_pin_prev;
        suppressed   = (i_item.last_turn_ms != '0)
                       && (turn_el < {16'd0, i_cfg.suppress_window_ms});
        startup_ok   = i_item.now_ms >= {16'd0, i_cfg.boot_hold_ms};

        // blink phase: bit 0 of elapsed / 200, only used while elapsed < 2^16
        blink_prod = {13'd0, wait_el[15:3]} * {13'd0, ocms_pkg::BLINK_RECIP};
        led = (r_mode == ocms_pkg::ST_WAIT)
              && (wait_el < {16'd0, i_cfg.blink_span_ms})
              && !blink_prod[ocms_pkg::BLINK_SHIFT];

        ang_x   = {i_item.target_angle[ocms_pkg::ANGLE_W-1], i_item.target_angle};
        lim_x   = $signed({2'b00, i_cfg.angle_limit});
        tgt_hit = i_item.target_seen
                  && (i_item.target_range <= i_cfg.range_limit)
                  && (ang_x <= lim_x) && (ang_x >= -lim_x);
        tgt_now   = r_tgt_latched || tgt_hit;
        angle_now = tgt_hit ? i_item.target_angle : r_lat_angle;

        n_mode        = r_mode;
        n_pin_prev    = i_item.junction_pin;
        n_wait_entry  = r_wait_entry;
        n_stop_entry  = r_stop_entry;
        n_avoid_entry = r_avoid_entry;
        n_tgt_latched = r_tgt_latched;
        n_lat_angle   = r_lat_angle;
        n_saved_side  = r_saved_side;
        halt          = 1'b0;
        swrite        = 1'b0;
        svalue        = 1'b0;

        case (r_mode)
            ocms_pkg::ST_STOP: begin
                n_tgt_latched = tgt_now;
                n_lat_angle   = angle_now;
                if (stop_el >= {16'd0, i_cfg.stop_hold_ms}) begin
                    if (tgt_now) begin
                        // steer away from the side the target sits on
                        swrite        = 1'b1;
                        svalue        = angle_now[ocms_pkg::ANGLE_W-1];
                        n_avoid_entry = i_item.now_ms;
                        n_mode        = ocms_pkg::ST_AVOID;
                    end else begin
                        n_mode = ocms_pkg::ST_FOLLOW;
                    end
                end
            end
            ocms_pkg::ST_AVOID: begin
                if (avoid_el >= {16'd0, i_cfg.avoid_span_ms}) begin
                    swrite = 1'b1;
                    svalue = r_saved_side;
                    n_mode = ocms_pkg::ST_FOLLOW;
                end
            end
            ocms_pkg::ST_WAIT: begin
                if (!i_item.junction_pin) begin
                    n_mode = ocms_pkg::ST_FOLLOW;
                end else if (sensors_dark) begin
                    halt          = 1'b1;
                    n_stop_entry  = i_item.now_ms;
                    n_tgt_latched = 1'b0;
                    n_mode        = ocms_pkg::ST_STOP;
                end else if (wait_el >= {16'd0, i_cfg.radar_wait_timeout_ms}) begin
                    n_mode = ocms_pkg::ST_FOLLOW;
                end
            end
            default: begin
                if (rise && !suppressed && startup_ok) begin
                    n_wait_entry = i_item.now_ms;
                    n_saved_side = i_item.steer_side;
                    n_mode       = ocms_pkg::ST_WAIT;
                end
            end
        endcase

        o_res.mode_state  = ocms_pkg::mode_code(n_mode);
        o_res.walk_enable = (r_mode != ocms_pkg::ST_STOP);
        o_res.halt_motors = halt;
        o_res.side_write  = swrite;
        o_res.side_value  = svalue;
        o_res.led_on      = led;
        o_res.radar_view  = (n_mode == ocms_pkg::ST_STOP) || (n_mode == ocms_pkg::ST_AVOID);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= ocms_pkg::ST_FOLLOW;
            r_pin_prev    <= 1'b0;
            r_wait_entry  <= '0;
            r_stop_entry  <= '0;
            r_avoid_entry <= '0;
            r_tgt_latched <= 1'b0;
            r_lat_angle   <= '0;
            r_saved_side  <= 1'b0;
        end else if (i_fire) begin
            r_mode        <= n_mode;
            r_pin_prev    <= n_pin_prev;
            r_wait_entry  <= n_wait_entry;
            r_stop_entry  <= n_stop_entry;
            r_avoid_entry <= n_avoid_entry;
            r_tgt_latched <= n_tgt_latched;
            r_lat_angle   <= n_lat_angle;
            r_saved_side  <= n_saved_side;
        end
    end

endmodule

FILE: src/obstacle_check_mode_sequencer.sv
// obstacle check mode sequencer: top level with input and result registers
// data path: a transfer on the input reaches the result through the input register,
//   then the state update and result register
// throughput: one item per cycle while the result register is empty or being drained
// reset: synchronous active-low i_rst_n clears both pipeline valids, the mode state
//   (follow, all entry times and latches zero) and loads the register defaults
module obstacle_check_mode_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ocms_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ocms_pkg::t_out                   o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ocms_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [ocms_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic            r_in_valid;
    ocms_pkg::t_in   r_in_data;
    logic            r_out_valid;
    ocms_pkg::t_out  r_out_data;
    ocms_pkg::t_cfg  cfg;
    ocms_pkg::t_out  res;
    logic            fire;

    // the held item moves on when the result register is empty or being drained
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;

    ocms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_idx   (i_cfg_addr),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    ocms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_data),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
        if (fire) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_halt_enters_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.halt_motors |-> o_out_data.mode_state == ocms_pkg::MODE_STOP)
        else $error("halt pulse without stop mode");

    a_radar_view_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.radar_view ==
            ((o_out_data.mode_state == ocms_pkg::MODE_STOP)
             || (o_out_data.mode_state == ocms_pkg::MODE_AVOID)))
        else $error("radar view does not match mode");

    a_side_value_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.side_write |-> !o_out_data.side_value)
        else $error("side value set without side write");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input stalled without a full pipeline");

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the obstacle check mode sequencer
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [31:0] BLINK_HALF_MS = 32'd200;
    // index past the last register, writes to it must be dropped
    localparam logic [ocms_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 4'd12;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ocms_pkg::t_in in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ocms_pkg::t_out out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ocms_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [ocms_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    obstacle_check_mode_sequencer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    ocms_pkg::t_in  pending_passes[$];
    ocms_pkg::t_out expected_results[$];
    int   items_queued = 0;
    int   mismatches = 0;
    int   cycle_count = 0;
    int   send_idle_pct = 9;
    int   recv_idle_pct = 74;

    // predicted sequencer state and register copy
    ocms_pkg::t_cfg seq_cfg;
    logic [1:0]  seq_mode = ocms_pkg::MODE_FOLLOW;
    logic        seq_pin_prev = 1'b0;
    logic [31:0] seq_wait_ms = '0;
    logic [31:0] seq_stop_ms = '0;
    logic [31:0] seq_avoid_ms = '0;
    logic        seq_latched = 1'b0;
    logic [15:0] seq_angle = '0;
    logic        seq_saved_side = 1'b0;

    function automatic ocms_pkg::t_cfg default_cfg();
        ocms_pkg::t_cfg c;
        c.suppress_window_ms    = ocms_pkg::RST_SUPPRESS;
        c.radar_wait_timeout_ms = ocms_pkg::RST_WAIT_TMO;
        c.stop_hold_ms          = ocms_pkg::RST_STOP_DUR;
        c.boot_hold_ms          = ocms_pkg::RST_STARTUP;
        c.blink_span_ms         = ocms_pkg::RST_LED_BLINK;
        c.avoid_span_ms         = ocms_pkg::RST_AVOID_TMO;
        c.range_limit           = ocms_pkg::RST_RANGE_LIM;
        c.angle_limit           = ocms_pkg::RST_ANGLE_LIM;
        return c;
    endfunction

    function automatic ocms_pkg::t_cfg random_cfg(input int unsigned hi);
        ocms_pkg::t_cfg c;
        c.suppress_window_ms    = 16'($urandom_range(0, hi));
        c.radar_wait_timeout_ms = 16'($urandom_range(0, hi));
        c.stop_hold_ms          = 16'($urandom_range(0, hi));
        c.boot_hold_ms          = 16'($urandom_range(0, hi));
        c.blink_span_ms         = 16'($urandom_range(0, hi));
        c.avoid_span_ms         = 16'($urandom_range(0, hi));
        c.range_limit           = 16'($urandom_range(0, hi));
        c.angle_limit           = 15'($urandom_range(0, (hi > 32767) ? 32767 : hi));
        return c;
    endfunction

    function automatic void apply_reg(input logic [ocms_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [ocms_pkg::CFG_DATA_W-1:0] d);
        case (idx)
            ocms_pkg::CFG_SUPPRESS:  seq_cfg.suppress_window_ms = d;
            ocms_pkg::CFG_WAIT_TMO:  seq_cfg.radar_wait_timeout_ms = d;
            ocms_pkg::CFG_STOP_DUR:  seq_cfg.stop_hold_ms = d;
            ocms_pkg::CFG_STARTUP:   seq_cfg.boot_hold_ms = d;
            ocms_pkg::CFG_LED_BLINK: seq_cfg.blink_span_ms = d;
            ocms_pkg::CFG_AVOID_TMO: seq_cfg.avoid_span_ms = d;
            ocms_pkg::CFG_RANGE_LIM: seq_cfg.range_limit = d;
            ocms_pkg::CFG_ANGLE_LIM: seq_cfg.angle_limit = d[ocms_pkg::ALIM_W-1:0];
            default: ;
        endcase
    endfunction

    // one control pass of the sequencer
    function automatic ocms_pkg::t_out predict_pass(input ocms_pkg::t_in p);
        ocms_pkg::t_out r;
        logic [31:0] since_turn, since_wait, since_stop, since_avoid, blink_slot;
        logic edge_up, suppressed, sensors_dark, target_ok;
        int ang, lim;
        r = '0;
        r.walk_enable = 1'b1;
        sensors_dark = (p.line_sensors == 8'h00);
        edge_up      = p.junction_pin && !seq_pin_prev;
        since_turn   = p.now_ms - p.last_turn_ms;
        suppressed   = (p.last_turn_ms != '0) && (since_turn < seq_cfg.suppress_window_ms);
        since_wait   = p.now_ms - seq_wait_ms;
        since_stop   = p.now_ms - seq_stop_ms;
        since_avoid  = p.now_ms - seq_avoid_ms;
        blink_slot   = since_wait / BLINK_HALF_MS;
        ang = int'(p.target_angle);
        lim = int'(seq_cfg.angle_limit);
        target_ok = p.target_seen && (p.target_range <= seq_cfg.range_limit)
                    && (ang >= -lim) && (ang <= lim);
        seq_pin_prev = p.junction_pin;

        if (seq_mode == ocms_pkg::MODE_WAIT && since_wait < seq_cfg.blink_span_ms
            && !blink_slot[0])
            r.led_on = 1'b1;

        case (seq_mode)
            ocms_pkg::MODE_STOP: begin
                r.walk_enable = 1'b0;
                // target is sampled before the timeout of the same pass
                if (target_ok) begin
                    seq_latched = 1'b1;
                    seq_angle   = p.target_angle;
                end
                if (since_stop >= seq_cfg.stop_hold_ms) begin
                    if (seq_latched) begin
                        r.side_write = 1'b1;
                        r.side_value = seq_angle[15];
                        seq_avoid_ms = p.now_ms;
                        seq_mode     = ocms_pkg::MODE_AVOID;
                    end else begin
                        seq_mode = ocms_pkg::MODE_FOLLOW;
                    end
                end
            end
            ocms_pkg::MODE_AVOID: begin
                if (since_avoid >= seq_cfg.avoid_span_ms) begin
                    r.side_write = 1'b1;
                    r.side_value = seq_saved_side;
                    seq_mode     = ocms_pkg::MODE_FOLLOW;
                end
            end
            ocms_pkg::MODE_WAIT: begin
                if (!p.junction_pin) begin
                    seq_mode = ocms_pkg::MODE_FOLLOW;
                end else if (sensors_dark) begin
                    r.halt_motors = 1'b1;
                    seq_stop_ms   = p.now_ms;
                    seq_latched   = 1'b0;
                    seq_mode      = ocms_pkg::MODE_STOP;
                end else if (since_wait >= seq_cfg.radar_wait_timeout_ms) begin
                    seq_mode = ocms_pkg::MODE_FOLLOW;
                end
            end
            default: begin
                if (edge_up && !suppressed && p.now_ms >= seq_cfg.boot_hold_ms) begin
                    seq_wait_ms    = p.now_ms;
                    seq_saved_side = p.steer_side;
                    seq_mode       = ocms_pkg::MODE_WAIT;
                end
            end
        endcase
        r.mode_state = seq_mode;
        r.radar_view = (seq_mode == ocms_pkg::MODE_STOP) || (seq_mode == ocms_pkg::MODE_AVOID);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [1:0] want,
                                        input logic [1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // input driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                expected_results.push_back(predict_pass(in_data));
            if (!in_valid || in_ready) begin
                if (pending_passes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending_passes.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : result_mon
        ocms_pkg::t_out want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("mode_state", want.mode_state, out_data.mode_state);
                    check_field("walk_enable", {1'b0, want.walk_enable},
                                {1'b0, out_data.walk_enable});
                    check_field("halt_motors", {1'b0, want.halt_motors},
                                {1'b0, out_data.halt_motors});
                    check_field("side_write", {1'b0, want.side_write},
                                {1'b0, out_data.side_write});
                    check_field("side_value", {1'b0, want.side_value},
                                {1'b0, out_data.side_value});
                    check_field("led_on", {1'b0, want.led_on}, {1'b0, out_data.led_on});
                    check_field("radar_view", {1'b0, want.radar_view},
                                {1'b0, out_data.radar_view});
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("obstacle_check_mode_sequencer test failed");
            $finish;
        end
    end

    task automatic add_item(input logic [31:0] now, input logic [7:0] sens, input logic pin,
                            input logic [31:0] turn, input logic side, input logic seen,
                            input logic [15:0] rng, input logic [15:0] ang);
        ocms_pkg::t_in p;
        p.now_ms       = now;
        p.line_sensors = sens;
        p.junction_pin = pin;
        p.last_turn_ms = turn;
        p.steer_side   = side;
        p.target_seen  = seen;
        p.target_range = rng;
        p.target_angle = ang;
        pending_passes.push_back(p);
        items_queued++;
    endtask

    // radar target around the acceptance limits
    task automatic pick_target(output logic seen, output logic [15:0] rng,
                               output logic [15:0] ang);
        int lim;
        lim  = int'(seq_cfg.angle_limit);
        seen = ($urandom_range(3) != 0);
        case ($urandom_range(3))
            0: rng = seq_cfg.range_limit;
            1: rng = seq_cfg.range_limit + 16'd1;
            2: rng = 16'($urandom_range(0, seq_cfg.range_limit));
            default: rng = 16'($urandom);
        endcase
        case ($urandom_range(6))
            0: ang = 16'(lim);
            1: ang = 16'(-lim);
            2: ang = 16'(lim + 1);
            3: ang = 16'(-lim - 1);
            4: ang = 16'h8000;
            5: ang = 16'($urandom_range(0, 2 * lim) - lim);
            default: ang = 16'($urandom);
        endcase
    endtask

    // junction edge and radar wait, then a pin drop, a wait timeout or a stop and avoid, with random content
    task automatic gen_episode(inout logic [31:0] t);
        logic [31:0] turn, t_wait, t_stop, t_avoid;
        logic side, seen, to_stop;
        logic [15:0] rng, ang;
        int n;
        side = 1'($urandom_range(1));
        t = t + $urandom_range(1, 400);
        add_item(t, 8'($urandom), 1'b0, $urandom, side, 1'b0, 16'($urandom), 16'($urandom));
        t = t + $urandom_range(1, 60);
        case ($urandom_range(4))
            0, 1: turn = '0;
            2: turn = t - seq_cfg.suppress_window_ms;
            3: turn = t - seq_cfg.suppress_window_ms + 32'd1;
            default: turn = t - $urandom_range(0, 3 * seq_cfg.suppress_window_ms + 10);
        endcase
        pick_target(seen, rng, ang);
        add_item(t, 8'($urandom_range(1, 255)), 1'b1, turn, side, seen, rng, ang);
        t_wait = t;
        n = $urandom_range(0, 4);
        repeat (n) begin
            // sometimes land right at the end of the blink window
            if ($urandom_range(4) == 0)
                t = t_wait + seq_cfg.blink_span_ms - $urandom_range(0, 1);
            else
                t = t + $urandom_range(0, 450);
            pick_target(seen, rng, ang);
            add_item(t, 8'($urandom_range(1, 255)), 1'b1, turn, 1'($urandom_range(1)),
                     seen, rng, ang);
        end
        to_stop = 1'b0;
        case ($urandom_range(9))
            6, 7: add_item(t + $urandom_range(0, 100), 8'($urandom), 1'b0, turn, side,
                           1'b0, 16'($urandom), 16'($urandom));
            8, 9: begin
                t = t_wait + seq_cfg.radar_wait_timeout_ms;
                add_item(t - 32'd1, 8'($urandom_range(1, 255)), 1'b1, turn, side, 1'b0,
                         '0, '0);
                add_item(t, 8'($urandom_range(1, 255)), 1'b1, turn, side, 1'b0, '0, '0);
            end
            default: begin
                t = t + $urandom_range(0, 200);
                add_item(t, 8'h00, 1'b1, turn, side, 1'b0, 16'($urandom), 16'($urandom));
                to_stop = 1'b1;
            end
        endcase
        if (to_stop) begin
            t_stop = t;
            n = $urandom_range(0, 4);
            repeat (n) begin
                if (seq_cfg.stop_hold_ms != 0)
                    t = t_stop + $urandom_range(0, seq_cfg.stop_hold_ms - 1);
                pick_target(seen, rng, ang);
                add_item(t, 8'($urandom), 1'($urandom_range(1)), $urandom,
                         1'($urandom_range(1)), seen, rng, ang);
            end
            t = t_stop + seq_cfg.stop_hold_ms + $urandom_range(0, 1);
            pick_target(seen, rng, ang);
            add_item(t, 8'($urandom), 1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                     seen, rng, ang);
            t_avoid = t;
            n = $urandom_range(0, 2);
            repeat (n) begin
                if (seq_cfg.avoid_span_ms != 0)
                    t = t_avoid + $urandom_range(0, seq_cfg.avoid_span_ms - 1);
                add_item(t, 8'($urandom), 1'($urandom_range(1)), $urandom,
                         1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom),
                         16'($urandom));
            end
            t = t_avoid + seq_cfg.avoid_span_ms + $urandom_range(0, 1);
            add_item(t, 8'($urandom_range(1, 255)), 1'b0, $urandom, side, 1'b0,
                     16'($urandom), 16'($urandom));
        end
    endtask

    task automatic gen_random(input int count);
        logic [31:0] t;
        int stop_at;
        stop_at = items_queued + count;
        t = $urandom;
        while (items_queued < stop_at) begin
            case ($urandom_range(7))
                0: t = $urandom_range(0, 70000);
                1: t = 32'hFFFF_FFFF - $urandom_range(0, 20000);
                default: ;
            endcase
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 4))
                    add_item($urandom, 8'($urandom), 1'($urandom_range(1)), $urandom,
                             1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom),
                             16'($urandom));
            end else begin
                gen_episode(t);
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_passes.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [ocms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ocms_pkg::CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, d);
    endtask

    // registers change only with the sequencer drained
    task automatic reconfigure(input ocms_pkg::t_cfg c, input logic stray, input int send_pct,
                               input int recv_pct);
        logic top_bit;
        wait_drained();
        @(posedge clk);
        if (stray)
            write_reg(CFG_NO_REG, 16'($urandom));
        write_reg(ocms_pkg::CFG_SUPPRESS, c.suppress_window_ms);
        write_reg(ocms_pkg::CFG_WAIT_TMO, c.radar_wait_timeout_ms);
        write_reg(ocms_pkg::CFG_STOP_DUR, c.stop_hold_ms);
        write_reg(ocms_pkg::CFG_STARTUP, c.boot_hold_ms);
        write_reg(ocms_pkg::CFG_LED_BLINK, c.blink_span_ms);
        write_reg(ocms_pkg::CFG_AVOID_TMO, c.avoid_span_ms);
        write_reg(ocms_pkg::CFG_RANGE_LIM, c.range_limit);
        // top data bit lies outside the angle limit and must be masked off
        top_bit = 1'($urandom_range(1));
        write_reg(ocms_pkg::CFG_ANGLE_LIM, {top_bit, c.angle_limit});
        cfg_valid <= 1'b0;
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial begin
        seq_cfg = default_cfg();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed passes on the reset settings
        add_item(32'd0,     8'hFF, 1'b1, 32'd0,    1'b0, 1'b0, 16'd0,  16'd0);  // startup
        add_item(32'd100,   8'hFF, 1'b0, 32'd0,    1'b0, 1'b0, 16'd0,  16'd0);
        add_item(32'd2500,  8'hFF, 1'b1, 32'd1500, 1'b0, 1'b0, 16'd0,  16'd0);  // suppressed
        add_item(32'd2600,  8'hFF, 1'b0, 32'd1500, 1'b0, 1'b0, 16'd0,  16'd0);
        add_item(32'd3000,  8'hFF, 1'b1, 32'd1500, 1'b1, 1'b0, 16'd0,  16'd0);
        add_item(32'd3199,  8'hFF, 1'b1, 32'd1500, 1'b1, 1'b0, 16'd0,  16'd0);  // led on
        add_item(32'd3200,  8'hFF, 1'b1, 32'd1500, 1'b1, 1'b0, 16'd0,  16'd0);  // led off
        // pin low wins over all black
        add_item(32'd3400,  8'h00, 1'b0, 32'd1500, 1'b1, 1'b0, 16'd0,  16'd0);
        add_item(32'd4000,  8'h7F, 1'b1, 32'd0,    1'b0, 1'b0, 16'd0,  16'd0);
        // all black wins over the wait timeout
        add_item(32'd9000,  8'h00, 1'b1, 32'd0,    1'b0, 1'b0, 16'd0,  16'd0);
        add_item(32'd9100,  8'hFF, 1'b1, 32'd0,    1'b0, 1'b1, 16'd60, -16'sd6000);
        add_item(32'd12000, 8'hFF, 1'b1, 32'd0,    1'b0, 1'b1, 16'd0,  16'sd6001);
        add_item(32'd27000, 8'h80, 1'b1, 32'd0,    1'b1, 1'b0, 16'd0,  16'd0);
        add_item(32'd27100, 8'h80, 1'b0, 32'd0,    1'b1, 1'b0, 16'd0,  16'd0);
        add_item(32'd30000, 8'h01, 1'b1, 32'd0,    1'b1, 1'b0, 16'd0,  16'd0);
        add_item(32'd30000, 8'h00, 1'b1, 32'd0,    1'b1, 1'b0, 16'd0,  16'd0);
        add_item(32'd30500, 8'hFF, 1'b1, 32'd0,    1'b1, 1'b1, 16'd61, 16'd0);
        // stop runs out with nothing latched
        add_item(32'd33000, 8'hFF, 1'b1, 32'd0,    1'b1, 1'b0, 16'd0,  16'd0);
        // entry just before the time wraps
        add_item(32'hFFFF_FF00, 8'hFF, 1'b0, 32'd0, 1'b1, 1'b0, 16'd0, 16'd0);
        add_item(32'hFFFF_FF80, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'd0, 16'd0);
        add_item(32'h0000_0010, 8'h00, 1'b1, 32'd0, 1'b0, 1'b0, 16'd0, 16'd0);
        add_item(32'h0000_0100, 8'hFF, 1'b0, 32'd0, 1'b0, 1'b1, 16'd60, 16'sd6000);
        add_item(32'd3016,  8'hFF, 1'b1, 32'd0,    1'b0, 1'b1, 16'hFFFF, 16'h8000);
        add_item(32'd18015, 8'hFF, 1'b1, 32'd0,    1'b0, 1'b0, 16'd0,  16'd0);
        add_item(32'd18016, 8'hFF, 1'b0, 32'd0,    1'b0, 1'b0, 16'd0,  16'd0);
        gen_random(125);

        reconfigure(random_cfg(600), 1'b0, 9, 74);
        gen_random(150);
        reconfigure('0, 1'b1, 74, 9);
        gen_random(125);
        reconfigure('1, 1'b0, 74, 9);
        gen_random(125);
        reconfigure(random_cfg(8000), 1'b1, 0, 0);
        gen_random(150);
        reconfigure(default_cfg(), 1'b0, 0, 0);
        gen_random(150);

        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("obstacle_check_mode_sequencer test passed");
        else
            $display("obstacle_check_mode_sequencer test failed");
        $finish;
    end

endmodule

FILE: sim.f
src/ocms_pkg.sv
src/ocms_cfg.sv
src/ocms_ctrl.sv
src/obstacle_check_mode_sequencer.sv
tb/testbench.sv
